>>> rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types, field widths and codes for the hash table engine.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int HTE_NUM_BUCKETS = 64;
    localparam int HTE_WAYS        = 4;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;

    // request opcodes; the unused code behaves as a lookup
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // response status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] STS_DUPLICATE = 2'd2;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd3;

    // storage port strobes from the sequencer
    typedef struct packed {
        logic row_rd;
        logic row_wr;
        logic ent_rd;
        logic ent_wr;
    } t_store_ctl;

endpackage

>>> rtl/hte_if.sv
// ----------------------------------------------------------------------------
// hte_req_if / hte_rsp_if
// Valid/ready channels for requests and responses of the hash table engine.
// ----------------------------------------------------------------------------
interface hte_req_if
    import hte_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface hte_rsp_if
    import hte_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

>>> rtl/hash_table_engine.sv
// ----------------------------------------------------------------------------
// hash_table_engine
// Key/value table with NUM_BUCKETS buckets of WAYS entries each. A request
// (lookup, insert or remove) picks its bucket from the low key bits, reads the
// bucket's valid mask, then walks the ways one at a time through a single
// shared key comparator, each way passing an entry read state and a compare
// state, stopping at the first hit. A final execute state writes the table
// and loads the response register, once any earlier response has drained.
// Only one request is in flight: ready is high only while the sequencer is
// idle. After reset the engine runs a clearing pass over the valid masks, one
// bucket per cycle, and accepts no request until it ends. Insert places the
// pair in the lowest free way; a duplicate key gives status 2, a full bucket
// status 3. NUM_BUCKETS must be a power of two.
// ----------------------------------------------------------------------------
module hash_table_engine
    import hte_pkg::*;
#(
    parameter int NUM_BUCKETS = HTE_NUM_BUCKETS,
    parameter int WAYS        = HTE_WAYS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hte_req_if.sink   i_req,
    hte_rsp_if.source o_rsp
);

    localparam int ENTRIES = NUM_BUCKETS * WAYS;
    localparam int ROW_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0]       r_state,     n_state;
    logic [ROW_W-1:0] r_clr_row,   n_clr_row;
    logic [OP_W-1:0]  r_op,        n_op;
    logic [KEY_W-1:0] r_key,       n_key;
    logic [VAL_W-1:0] r_val,       n_val;
    logic [WAY_W-1:0] r_way,       n_way;
    logic             r_hit,       n_hit;
    logic [WAY_W-1:0] r_hit_way,   n_hit_way;
    logic [VAL_W-1:0] r_hit_val,   n_hit_val;
    logic             r_out_valid, n_out_valid;
    logic [STS_W-1:0] r_status,    n_status;
    logic [VAL_W-1:0] r_result,    n_result;

    t_store_ctl       w_ctl;
    logic [ROW_W-1:0] w_row_addr;
    logic [WAYS-1:0]  w_row_wdata;
    logic [WAYS-1:0]  w_vrow;
    logic [ENT_W-1:0] w_ent_addr;
    logic [KEY_W-1:0] w_key_rd;
    logic [VAL_W-1:0] w_val_rd;
    logic             w_hit;
    logic             w_free_found;
    logic [WAY_W-1:0] w_free_way;

    logic             w_req_fire;
    logic [ROW_W-1:0] w_req_bucket;
    logic [ROW_W-1:0] w_bucket;
    logic [ENT_W-1:0] w_base;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_fire  = i_req.valid && i_req.ready;

    // bucket = key mod NUM_BUCKETS (power of two: low key bits)
    assign w_req_bucket = ROW_W'(i_req.key % NUM_BUCKETS);
    assign w_bucket     = ROW_W'(r_key % NUM_BUCKETS);
    assign w_base       = ENT_W'(32'(w_bucket) * WAYS);

    hte_store #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_row_addr  (w_row_addr),
        .i_row_wdata (w_row_wdata),
        .o_row_rdata (w_vrow),
        .i_ent_addr  (w_ent_addr),
        .i_key_wdata (r_key),
        .i_val_wdata (r_val),
        .o_key_rdata (w_key_rd),
        .o_val_rdata (w_val_rd)
    );

    hte_match #(
        .WAYS (WAYS)
    ) u_match (
        .i_vrow       (w_vrow),
        .i_way        (r_way),
        .i_key_rd     (w_key_rd),
        .i_key        (r_key),
        .o_hit        (w_hit),
        .o_free_found (w_free_found),
        .o_free_way   (w_free_way)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_row   = r_clr_row;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_way       = r_way;
        n_hit       = r_hit;
        n_hit_way   = r_hit_way;
        n_hit_val   = r_hit_val;
        n_status    = r_status;
        n_result    = r_result;
        // response register drains on its handshake
        n_out_valid = r_out_valid && !o_rsp.ready;

        w_ctl       = '0;
        w_row_addr  = w_bucket;
        w_row_wdata = '0;
        w_ent_addr  = w_base + ENT_W'(r_way);

        unique case (r_state)
            S_CLEAR: begin
                // zero one bucket's valid mask per cycle
                w_ctl.row_wr = 1'b1;
                w_row_addr   = r_clr_row;
                n_clr_row    = r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_W'(NUM_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_req_fire) begin
                    w_ctl.row_rd = 1'b1;
                    w_row_addr   = w_req_bucket;
                    n_op         = i_req.opcode;
                    n_key        = i_req.key;
                    n_val        = i_req.value;
                    n_way        = '0;
                    n_hit        = 1'b0;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                w_ctl.ent_rd = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (w_hit) begin
                    n_hit     = 1'b1;
                    n_hit_way = r_way;
                    n_hit_val = w_val_rd;
                    n_state   = S_EXEC;
                end else if (r_way == WAY_W'(WAYS - 1)) begin
                    n_state = S_EXEC;
                end else begin
                    n_way   = r_way + WAY_W'(1);
                    n_state = S_READ;
                end
            end
            S_EXEC: begin
                // commit only when the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_result    = '0;
                    n_state     = S_IDLE;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_hit) begin
                                n_status = STS_DUPLICATE;
                            end else if (!w_free_found) begin
                                n_status = STS_FULL;
                            end else begin
                                w_ctl.ent_wr = 1'b1;
                                w_ent_addr   = w_base + ENT_W'(w_free_way);
                                w_ctl.row_wr = 1'b1;
                                w_row_wdata  = w_vrow | (WAYS'(1) << w_free_way);
                                n_status     = STS_OK;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                w_ctl.row_wr = 1'b1;
                                w_row_wdata  = w_vrow & ~(WAYS'(1) << r_hit_way);
                                n_status     = STS_OK;
                                n_result     = r_hit_val;
                            end else begin
                                n_status = STS_NOT_FOUND;
                            end
                        end
                        default: begin
                            // lookup, and the unused opcode
                            if (r_hit) begin
                                n_status = STS_OK;
                                n_result = r_hit_val;
                            end else begin
                                n_status = STS_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_way       <= n_way;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_hit_way <= n_hit_way;
        r_hit_val <= n_hit_val;
        r_status  <= n_status;
        r_result  <= n_result;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.result_value = r_result;

`ifndef SYNTHESIS
    // no request is taken before the valid masks are cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("request accepted during clearing pass");

    // the way counter never leaves the bucket
    a_way_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CMP) |-> (32'(r_way) < WAYS))
        else $error("way counter out of range");

    // an insert or remove flips exactly one valid bit of the bucket
    a_one_valid_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_ctl.row_wr) |-> ($countones(w_row_wdata ^ w_vrow) == 1))
        else $error("valid mask update changes other than one way");

    // an accepted request starts the way scan next cycle
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> (r_state == S_READ && r_way == '0 && !r_hit))
        else $error("scan did not start after request");
`endif

endmodule

>>> rtl/hte_store.sv
// ----------------------------------------------------------------------------
// hte_store
// Table storage: one valid-mask row per bucket, key and value per entry.
// ----------------------------------------------------------------------------
module hte_store
    import hte_pkg::*;
#(
    parameter int NUM_BUCKETS = HTE_NUM_BUCKETS,
    parameter int WAYS        = HTE_WAYS
) (
    input  logic             i_clk,
    input  t_store_ctl       i_ctl,
    input  logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] i_row_addr,
    input  logic [WAYS-1:0]  i_row_wdata,
    output logic [WAYS-1:0]  o_row_rdata,
    input  logic [((NUM_BUCKETS*WAYS) > 1 ? $clog2(NUM_BUCKETS*WAYS) : 1)-1:0] i_ent_addr,
    input  logic [KEY_W-1:0] i_key_wdata,
    input  logic [VAL_W-1:0] i_val_wdata,
    output logic [KEY_W-1:0] o_key_rdata,
    output logic [VAL_W-1:0] o_val_rdata
);

    localparam int ENTRIES = NUM_BUCKETS * WAYS;

    logic [WAYS-1:0]  r_row_mem [NUM_BUCKETS];
    logic [KEY_W-1:0] r_key_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];
    logic [WAYS-1:0]  r_row_rdata;
    logic [KEY_W-1:0] r_key_rdata;
    logic [VAL_W-1:0] r_val_rdata;

    // valid masks: one port, read or write per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.row_wr) begin
            r_row_mem[i_row_addr] <= i_row_wdata;
        end else if (i_ctl.row_rd) begin
            r_row_rdata <= r_row_mem[i_row_addr];
        end
    end

    // entries: key and value share one address
    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_wr) begin
            r_key_mem[i_ent_addr] <= i_key_wdata;
            r_val_mem[i_ent_addr] <= i_val_wdata;
        end else if (i_ctl.ent_rd) begin
            r_key_rdata <= r_key_mem[i_ent_addr];
            r_val_rdata <= r_val_mem[i_ent_addr];
        end
    end

    assign o_row_rdata = r_row_rdata;
    assign o_key_rdata = r_key_rdata;
    assign o_val_rdata = r_val_rdata;

endmodule

>>> rtl/hte_match.sv
// ----------------------------------------------------------------------------
// hte_match
// Shared compare unit: key match for one way, lowest free way of the row.
// ----------------------------------------------------------------------------
module hte_match
    import hte_pkg::*;
#(
    parameter int WAYS = HTE_WAYS
) (
    input  logic [WAYS-1:0]  i_vrow,
    input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] i_way,
    input  logic [KEY_W-1:0] i_key_rd,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_hit,
    output logic             o_free_found,
    output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] o_free_way
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    assign o_hit = i_vrow[i_way] && (i_key_rd == i_key);

    // scan from the top so the lowest free way wins
    always_comb begin
        o_free_found = 1'b0;
        o_free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!i_vrow[w]) begin
                o_free_found = 1'b1;
                o_free_way   = WAY_W'(w);
            end
        end
    end

endmodule
